@@ sv/tmsc_pkg.sv @@
`default_nettype none
package tmsc_pkg;

    localparam int MAP_COLS_DEF = 64;
    localparam int MAP_ROWS_DEF = 64;
    localparam int STORE_DEPTH  = 4096;
    localparam int STORE_AW     = 12;
    localparam int FLAG_W       = 8;
    localparam int POS_W        = 18;
    localparam int IDX_W        = 17;
    localparam int TILE_W       = 7;
    localparam int SIZE_W       = 10;
    localparam int MOVE_W       = 12;
    localparam int STEP_W       = 13;
    localparam int CFG_IDX_W    = 3;
    localparam int CFG_DATA_W   = 16;
    localparam int S_DATA_W     = 96;
    localparam int M_DATA_W     = 32;

    localparam logic signed [15:0] BOUND_RESET_LO = -16'sd32767;
    localparam logic signed [15:0] BOUND_RESET_HI = 16'sd32767;
    localparam logic [TILE_W-1:0]  TILE_RESET     = 7'd8;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SOLID_MASK  = 3'd0,
        CFG_BOUND_MIN_X = 3'd1,
        CFG_BOUND_MIN_Y = 3'd2,
        CFG_BOUND_MAX_X = 3'd3,
        CFG_BOUND_MAX_Y = 3'd4,
        CFG_TILE_WIDTH  = 3'd5,
        CFG_TILE_HEIGHT = 3'd6
    } t_cfg_reg;

    typedef enum logic {
        OP_WRITE = 1'b0,
        OP_MOVE  = 1'b1
    } t_op;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_AXIS,
        ST_DSTEP,
        ST_APPLY,
        ST_CHECK,
        ST_DIVS,
        ST_RANGE,
        ST_SCAN,
        ST_FIN
    } t_state;

    typedef struct packed {
        logic                     start;
        logic signed [POS_W-1:0]  num;
        logic [TILE_W-1:0]        den;
    } t_div_req;

    typedef struct packed {
        logic                     done;
        logic signed [POS_W-1:0]  quo;
        logic [TILE_W-1:0]        modulo;
    } t_div_rsp;

endpackage
`default_nettype wire

@@ sv/tmsc_ram.sv @@
`default_nettype none
module tmsc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4096
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule
`default_nettype wire

@@ sv/tmsc_fdiv.sv @@
`default_nettype none
module tmsc_fdiv (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire tmsc_pkg::t_div_req i_req,
    output tmsc_pkg::t_div_rsp      o_rsp
);

    localparam int PW = tmsc_pkg::POS_W;
    localparam int TW = tmsc_pkg::TILE_W;
    localparam int CW = $clog2(PW + 1);

    logic          r_busy;
    logic          r_done;
    logic [CW-1:0] r_cnt;
    logic [PW-1:0] r_num;
    logic [TW-1:0] r_rem;
    logic [TW-1:0] r_den;
    logic          r_neg;

    logic [TW:0]   trial;
    logic          qbit;
    logic [TW-1:0] n_rem;
    logic          rnz;

    always_comb begin
        trial = {r_rem, r_num[PW-1]};
        qbit  = (trial >= {1'b0, r_den});
        n_rem = qbit ? TW'(trial - {1'b0, r_den}) : trial[TW-1:0];
        rnz   = (r_rem != '0);
        o_rsp.done   = r_done;
        o_rsp.quo    = r_neg ? ($signed(-r_num) - $signed(PW'(rnz))) : $signed(r_num);
        o_rsp.modulo = (r_neg && rnz) ? TW'(r_den - r_rem) : r_rem;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= CW'(PW);
                r_num  <= i_req.num[PW-1] ? PW'(-i_req.num) : PW'(i_req.num);
                r_neg  <= i_req.num[PW-1];
                r_rem  <= '0;
                r_den  <= i_req.den;
            end else if (r_busy) begin
                r_num <= {r_num[PW-2:0], qbit};
                r_rem <= n_rem;
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

endmodule
`default_nettype wire

@@ sv/tile_map_swept_collision.sv @@
`default_nettype none
// Swept rectangle motion against a tile flag map. Input beats with operation
// 0 store one flag byte and leave the input ready for the next beat; beats
// with operation 1 move the rectangle, X first, then Y, and return one result
// beat. A move is accepted in the idle state, each axis is closed when its
// displacement runs out, and the result register is loaded once the output is
// free. Each axis step sets up, runs the tile-edge floor division, applies the
// step and checks the bounds; the division is skipped when that axis has tile
// size zero. A step that stays in bounds with tile checks enabled then runs
// four floor divisions for the covered tile range and a range check; if that
// range touches the map, a scan follows with one flag read per covered tile,
// ending early on a solid tile. All divisions use the shared serial divider
// and all flag reads the single memory read port. The input stalls while a
// move runs.
module tile_map_swept_collision #(
    parameter int MAP_COLS = tmsc_pkg::MAP_COLS_DEF,
    parameter int MAP_ROWS = tmsc_pkg::MAP_ROWS_DEF
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_cfg_we,
    input  wire logic [tmsc_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  wire logic [tmsc_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    input  wire logic                             i_s_axis_tvalid,
    output logic                                  o_s_axis_tready,
    // tile_index[11:0] tile_flags[19:12] rect_x[35:20] rect_y[51:36]
    // rect_w[61:52] rect_h[71:62] move_x[83:72] move_y[95:84]
    input  wire logic [tmsc_pkg::S_DATA_W-1:0]    i_s_axis_tdata,
    // operation[0]
    input  wire logic                             i_s_axis_tuser,
    output logic                                  o_m_axis_tvalid,
    input  wire logic                             i_m_axis_tready,
    // moved_x[11:0] moved_y[23:12] hit_x[24] hit_y[25] zero[31:26]
    output logic [tmsc_pkg::M_DATA_W-1:0]         o_m_axis_tdata
);

    localparam int PW  = tmsc_pkg::POS_W;
    localparam int TW  = tmsc_pkg::TILE_W;
    localparam int SW  = tmsc_pkg::SIZE_W;
    localparam int MW  = tmsc_pkg::MOVE_W;
    localparam int STW = tmsc_pkg::STEP_W;
    localparam int XW  = tmsc_pkg::IDX_W;
    localparam int AW  = tmsc_pkg::STORE_AW;
    localparam int FW  = tmsc_pkg::FLAG_W;
    localparam int CW  = (MAP_COLS > 1) ? $clog2(MAP_COLS) : 1;
    localparam int RW  = (MAP_ROWS > 1) ? $clog2(MAP_ROWS) : 1;

    tmsc_pkg::t_state r_state, n_state;

    logic [FW-1:0]        r_mask;
    logic signed [15:0]   r_bminx, r_bminy, r_bmaxx, r_bmaxy;
    logic [TW-1:0]        r_tw, r_th;

    logic signed [PW-1:0] r_x, r_y, r_x0, r_y0, r_npos;
    logic [SW-1:0]        r_w, r_h;
    logic signed [MW-1:0] r_rem, r_my;
    logic signed [STW-1:0] r_step;
    logic                 r_axis, r_hx, r_hy;
    logic [1:0]           r_dsel;
    logic                 r_dwait;
    logic signed [PW-1:0] r_q [4];
    logic [CW-1:0]        r_c, r_c0c, r_c1c;
    logic [RW-1:0]        r_r, r_r1c;
    logic                 r_iss, r_rd_vld;
    logic                 r_ovld;
    logic [tmsc_pkg::M_DATA_W-1:0] r_odata;

    tmsc_pkg::t_div_req   div_req;
    tmsc_pkg::t_div_rsp   div_rsp;

    logic                 s_acc;
    logic signed [PW-1:0] pos, cx, cy;
    logic [SW-1:0]        size;
    logic [TW-1:0]        tile;
    logic                 rem_pos;
    logic [MW:0]          rem_mag;
    logic [TW:0]          mstep;
    logic [MW:0]          smag;
    logic                 bnd_fail, no_tile, out_map, hit, last;
    logic [XW-1:0]        idx;
    logic                 idx_ok, rd_en;
    logic [FW-1:0]        rdata;
    logic                 do_adv, do_end, do_hit, do_load;

    assign s_acc = i_s_axis_tvalid && o_s_axis_tready;
    assign o_s_axis_tready = (r_state == tmsc_pkg::ST_IDLE);
    assign o_m_axis_tvalid = r_ovld;
    assign o_m_axis_tdata  = r_odata;

    always_comb begin
        pos     = r_axis ? r_y : r_x;
        size    = r_axis ? r_h : r_w;
        tile    = r_axis ? r_th : r_tw;
        rem_pos = !r_rem[MW-1];
        rem_mag = r_rem[MW-1] ? (MW+1)'(-{r_rem[MW-1], r_rem}) : {1'b0, r_rem};
        mstep   = rem_pos ? (TW+1)'({1'b0, tile} - {1'b0, div_rsp.modulo})
                          : (TW+1)'({1'b0, div_rsp.modulo} + 1'b1);
        smag    = ((MW+1)'(mstep) < rem_mag) ? (MW+1)'(mstep) : rem_mag;
        cx      = r_axis ? r_x : r_npos;
        cy      = r_axis ? r_npos : r_y;
        bnd_fail = (cx < PW'(r_bminx)) || (cy < PW'(r_bminy))
                || ((cx + $signed({{(PW-SW){1'b0}}, r_w})) > PW'(r_bmaxx))
                || ((cy + $signed({{(PW-SW){1'b0}}, r_h})) > PW'(r_bmaxy));
        no_tile = (r_w == '0) || (r_h == '0) || (r_tw == '0) || (r_th == '0);
        out_map = r_q[1][PW-1] || r_q[3][PW-1]
               || (r_q[0] >= $signed(PW'(MAP_COLS)))
               || (r_q[2] >= $signed(PW'(MAP_ROWS)));
        idx     = XW'(XW'(r_r) * XW'(MAP_COLS)) + XW'(r_c);
        idx_ok  = (32'(idx) < 32'(tmsc_pkg::STORE_DEPTH));
        last    = (r_c == r_c1c) && (r_r == r_r1c);
        rd_en   = (r_state == tmsc_pkg::ST_SCAN) && r_iss && idx_ok;
        hit     = r_rd_vld && ((rdata & r_mask) != '0);

        div_req.start = 1'b0;
        div_req.num   = '0;
        div_req.den   = tile;
        case (r_state)
            tmsc_pkg::ST_AXIS: begin
                div_req.start = (r_rem != '0) && (tile != '0);
                div_req.num   = rem_pos ? (pos + $signed({{(PW-SW){1'b0}}, size}))
                                        : (pos - PW'(1));
            end
            tmsc_pkg::ST_DIVS: begin
                div_req.start = !r_dwait;
                div_req.den   = r_dsel[1] ? r_th : r_tw;
                case (r_dsel)
                    2'd0: div_req.num = cx;
                    2'd1: div_req.num = cx + $signed({{(PW-SW){1'b0}}, r_w}) - PW'(1);
                    2'd2: div_req.num = cy;
                    default: div_req.num = cy + $signed({{(PW-SW){1'b0}}, r_h}) - PW'(1);
                endcase
            end
            default: ;
        endcase
    end

    always_comb begin
        n_state = r_state;
        do_adv  = 1'b0;
        do_end  = 1'b0;
        do_hit  = 1'b0;
        do_load = 1'b0;
        case (r_state)
            tmsc_pkg::ST_IDLE: begin
                if (s_acc && (i_s_axis_tuser == tmsc_pkg::OP_MOVE)) begin
                    n_state = tmsc_pkg::ST_AXIS;
                end
            end
            tmsc_pkg::ST_AXIS: begin
                if (r_rem == '0) begin
                    do_end = 1'b1;
                end else if (tile == '0) begin
                    n_state = tmsc_pkg::ST_APPLY;
                end else begin
                    n_state = tmsc_pkg::ST_DSTEP;
                end
            end
            tmsc_pkg::ST_DSTEP: begin
                if (div_rsp.done) begin
                    n_state = tmsc_pkg::ST_APPLY;
                end
            end
            tmsc_pkg::ST_APPLY: n_state = tmsc_pkg::ST_CHECK;
            tmsc_pkg::ST_CHECK: begin
                if (bnd_fail) begin
                    do_hit = 1'b1;
                    do_end = 1'b1;
                end else if (no_tile) begin
                    do_adv = 1'b1;
                end else begin
                    n_state = tmsc_pkg::ST_DIVS;
                end
            end
            tmsc_pkg::ST_DIVS: begin
                if (div_rsp.done && (r_dsel == 2'd3)) begin
                    n_state = tmsc_pkg::ST_RANGE;
                end
            end
            tmsc_pkg::ST_RANGE: begin
                if (out_map) begin
                    do_adv = 1'b1;
                end else begin
                    n_state = tmsc_pkg::ST_SCAN;
                end
            end
            tmsc_pkg::ST_SCAN: begin
                if (hit) begin
                    do_hit = 1'b1;
                    do_end = 1'b1;
                end else if (!r_iss && !r_rd_vld) begin
                    do_adv = 1'b1;
                end
            end
            tmsc_pkg::ST_FIN: begin
                if (!r_ovld || i_m_axis_tready) begin
                    do_load = 1'b1;
                    n_state = tmsc_pkg::ST_IDLE;
                end
            end
            default: n_state = tmsc_pkg::ST_IDLE;
        endcase
        if (do_adv) begin
            n_state = tmsc_pkg::ST_AXIS;
        end
        if (do_end) begin
            n_state = r_axis ? tmsc_pkg::ST_FIN : tmsc_pkg::ST_AXIS;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= tmsc_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mask  <= '0;
            r_bminx <= tmsc_pkg::BOUND_RESET_LO;
            r_bminy <= tmsc_pkg::BOUND_RESET_LO;
            r_bmaxx <= tmsc_pkg::BOUND_RESET_HI;
            r_bmaxy <= tmsc_pkg::BOUND_RESET_HI;
            r_tw    <= tmsc_pkg::TILE_RESET;
            r_th    <= tmsc_pkg::TILE_RESET;
        end else if (i_cfg_we) begin
            case (tmsc_pkg::t_cfg_reg'(i_cfg_idx))
                tmsc_pkg::CFG_SOLID_MASK:  r_mask  <= i_cfg_data[FW-1:0];
                tmsc_pkg::CFG_BOUND_MIN_X: r_bminx <= $signed(i_cfg_data);
                tmsc_pkg::CFG_BOUND_MIN_Y: r_bminy <= $signed(i_cfg_data);
                tmsc_pkg::CFG_BOUND_MAX_X: r_bmaxx <= $signed(i_cfg_data);
                tmsc_pkg::CFG_BOUND_MAX_Y: r_bmaxy <= $signed(i_cfg_data);
                tmsc_pkg::CFG_TILE_WIDTH:  r_tw    <= i_cfg_data[TW-1:0];
                tmsc_pkg::CFG_TILE_HEIGHT: r_th    <= i_cfg_data[TW-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovld   <= 1'b0;
            r_iss    <= 1'b0;
            r_rd_vld <= 1'b0;
            r_dwait  <= 1'b0;
        end else begin
            if (o_m_axis_tvalid && i_m_axis_tready) begin
                r_ovld <= 1'b0;
            end
            if (do_load) begin
                r_ovld  <= 1'b1;
                r_odata <= {6'd0, r_hy, r_hx, MW'(r_y - r_y0), MW'(r_x - r_x0)};
            end
            r_rd_vld <= rd_en;

            case (r_state)
                tmsc_pkg::ST_IDLE: begin
                    r_x    <= PW'($signed(i_s_axis_tdata[35:20]));
                    r_x0   <= PW'($signed(i_s_axis_tdata[35:20]));
                    r_y    <= PW'($signed(i_s_axis_tdata[51:36]));
                    r_y0   <= PW'($signed(i_s_axis_tdata[51:36]));
                    r_w    <= i_s_axis_tdata[61:52];
                    r_h    <= i_s_axis_tdata[71:62];
                    r_rem  <= $signed(i_s_axis_tdata[83:72]);
                    r_my   <= $signed(i_s_axis_tdata[95:84]);
                    r_axis <= 1'b0;
                    r_hx   <= 1'b0;
                    r_hy   <= 1'b0;
                end
                tmsc_pkg::ST_AXIS: begin
                    r_step <= STW'(r_rem);
                end
                tmsc_pkg::ST_DSTEP: begin
                    r_step <= rem_pos ? $signed(STW'(smag)) : -$signed(STW'(smag));
                end
                tmsc_pkg::ST_APPLY: begin
                    r_npos <= pos + PW'(r_step);
                end
                tmsc_pkg::ST_CHECK: begin
                    r_dsel  <= 2'd0;
                    r_dwait <= 1'b0;
                end
                tmsc_pkg::ST_DIVS: begin
                    if (!r_dwait) begin
                        r_dwait <= 1'b1;
                    end else if (div_rsp.done) begin
                        r_q[r_dsel] <= div_rsp.quo;
                        r_dsel      <= r_dsel + 1'b1;
                        r_dwait     <= 1'b0;
                    end
                end
                tmsc_pkg::ST_RANGE: begin
                    r_c   <= r_q[0][PW-1] ? '0 : r_q[0][CW-1:0];
                    r_c0c <= r_q[0][PW-1] ? '0 : r_q[0][CW-1:0];
                    r_r   <= r_q[2][PW-1] ? '0 : r_q[2][RW-1:0];
                    r_c1c <= (r_q[1] >= $signed(PW'(MAP_COLS))) ? CW'(MAP_COLS - 1)
                                                                : r_q[1][CW-1:0];
                    r_r1c <= (r_q[3] >= $signed(PW'(MAP_ROWS))) ? RW'(MAP_ROWS - 1)
                                                                : r_q[3][RW-1:0];
                    r_iss <= 1'b1;
                end
                tmsc_pkg::ST_SCAN: begin
                    if (r_iss) begin
                        if (last) begin
                            r_iss <= 1'b0;
                        end else if (r_c == r_c1c) begin
                            r_c <= r_c0c;
                            r_r <= r_r + 1'b1;
                        end else begin
                            r_c <= r_c + 1'b1;
                        end
                    end
                    if (hit) begin
                        r_iss <= 1'b0;
                    end
                end
                default: ;
            endcase

            if (do_adv) begin
                if (r_axis) begin
                    r_y <= r_npos;
                end else begin
                    r_x <= r_npos;
                end
                r_rem <= r_rem - MW'(r_step);
            end
            if (do_hit) begin
                if (r_axis) begin
                    r_hy <= 1'b1;
                end else begin
                    r_hx <= 1'b1;
                end
            end
            if (do_end && !r_axis) begin
                r_axis <= 1'b1;
                r_rem  <= r_my;
            end
        end
    end

    tmsc_fdiv u_fdiv (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    tmsc_ram #(
        .WIDTH (FW),
        .DEPTH (tmsc_pkg::STORE_DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (s_acc && (i_s_axis_tuser == tmsc_pkg::OP_WRITE)),
        .i_waddr (i_s_axis_tdata[AW-1:0]),
        .i_wdata (i_s_axis_tdata[19:12]),
        .i_re    (rd_en),
        .i_raddr (idx[AW-1:0]),
        .o_rdata (rdata)
    );

endmodule
`default_nettype wire

@@ tb/tb_tile_map_swept_collision.sv @@
`default_nettype none
module tb_tile_map_swept_collision;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int COLS = 64;
    localparam int ROWS = 64;
    localparam int REGION = 16;
    localparam int CYCLE_LIMIT = 20000000;

    typedef struct {
        logic signed [11:0] dx;
        logic signed [11:0] dy;
        logic               hx;
        logic               hy;
    } t_motion;

    logic                            i_clk = 1'b0;
    logic                            i_rst_n = 1'b0;
    logic                            cfg_we = 1'b0;
    logic [tmsc_pkg::CFG_IDX_W-1:0]  cfg_idx = '0;
    logic [tmsc_pkg::CFG_DATA_W-1:0] cfg_data = '0;
    logic                            s_valid = 1'b0;
    logic                            s_ready;
    logic [tmsc_pkg::S_DATA_W-1:0]   s_data = '0;
    logic                            s_user = 1'b0;
    logic                            m_valid;
    logic                            m_ready = 1'b0;
    logic [tmsc_pkg::M_DATA_W-1:0]   m_data;

    // predictor state
    logic [7:0] tile_flags_map [tmsc_pkg::STORE_DEPTH];
    int mask_q = 0;
    int bmin_x = -32767, bmin_y = -32767, bmax_x = 32767, bmax_y = 32767;
    int tile_w = 8, tile_h = 8;

    t_motion motion_q[$];
    int  errors = 0;
    int  cycles = 0;
    bit  quiet = 1'b0;
    bit  hold_req = 1'b0;
    int  hold_cnt = 0;

    tile_map_swept_collision dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_we(cfg_we), .i_cfg_idx(cfg_idx), .i_cfg_data(cfg_data),
        .i_s_axis_tvalid(s_valid), .o_s_axis_tready(s_ready),
        .i_s_axis_tdata(s_data), .i_s_axis_tuser(s_user),
        .o_m_axis_tvalid(m_valid), .i_m_axis_tready(m_ready),
        .o_m_axis_tdata(m_data)
    );

    always #4 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    function automatic int fdiv(input int a, input int b);
        int q;
        q = a / b;
        if ((a % b) < 0) q--;
        return q;
    endfunction

    function automatic bit rect_on_wall(input int x, input int y, input int w, input int h);
        int c0, r0, c1, r1;
        if (tile_w <= 0 || tile_h <= 0 || w <= 0 || h <= 0) return 1'b0;
        c0 = fdiv(x, tile_w);
        r0 = fdiv(y, tile_h);
        c1 = fdiv(x + w - 1, tile_w);
        r1 = fdiv(y + h - 1, tile_h);
        if (c1 < 0 || r1 < 0 || c0 >= COLS || r0 >= ROWS) return 1'b0;
        if (c0 < 0) c0 = 0;
        if (r0 < 0) r0 = 0;
        if (c1 >= COLS) c1 = COLS - 1;
        if (r1 >= ROWS) r1 = ROWS - 1;
        for (int r = r0; r <= r1; r++)
            for (int c = c0; c <= c1; c++)
                if ((r * COLS + c) < tmsc_pkg::STORE_DEPTH &&
                    (tile_flags_map[r * COLS + c] & mask_q[7:0]) != 0)
                    return 1'b1;
        return 1'b0;
    endfunction

    function automatic bit pos_blocked(input int x, input int y, input int w, input int h);
        if (x < bmin_x || y < bmin_y || x + w > bmax_x || y + h > bmax_y) return 1'b1;
        return rect_on_wall(x, y, w, h);
    endfunction

    function automatic int edge_step(input int lo, input int size, input int tile, input int rem);
        int e, te, d;
        if (tile <= 0) return rem;
        if (rem > 0) begin
            e = lo + size;
            te = (fdiv(e, tile) + 1) * tile;
            d = te - e;
            if (d < 1) d = 1;
            if (d > rem) d = rem;
            return d;
        end
        te = fdiv(lo - 1, tile) * tile;
        d = lo - te;
        if (d < 1) d = 1;
        if (-d < rem) d = -rem;
        return -d;
    endfunction

    function automatic t_motion sweep_rect(input int x0, input int y0, input int w, input int h,
                                           input int mx, input int my);
        t_motion res;
        int x, y, rem, st;
        x = x0;
        y = y0;
        res.hx = 1'b0;
        res.hy = 1'b0;
        rem = mx;
        while (rem != 0) begin
            st = edge_step(x, w, tile_w, rem);
            if (pos_blocked(x + st, y, w, h)) begin
                res.hx = 1'b1;
                break;
            end
            x += st;
            rem -= st;
        end
        rem = my;
        while (rem != 0) begin
            st = edge_step(y, h, tile_h, rem);
            if (pos_blocked(x, y + st, w, h)) begin
                res.hy = 1'b1;
                break;
            end
            y += st;
            rem -= st;
        end
        res.dx = 12'(x - x0);
        res.dy = 12'(y - y0);
        return res;
    endfunction

    // result side: random ready (always ready when quiet), long hold-off on request, compare each beat
    always @(posedge i_clk) begin
        t_motion want;
        if (m_valid && m_ready) begin
            if (motion_q.size() == 0) begin
                $display("%0t: unexpected result beat %h", $time, m_data);
                errors++;
            end else begin
                want = motion_q.pop_front();
                if (m_data[11:0] !== want.dx) begin
                    $display("%0t: moved_x exp %0d got %0d", $time, want.dx,
                             $signed(m_data[11:0]));
                    errors++;
                end
                if (m_data[23:12] !== want.dy) begin
                    $display("%0t: moved_y exp %0d got %0d", $time, want.dy,
                             $signed(m_data[23:12]));
                    errors++;
                end
                if (m_data[24] !== want.hx) begin
                    $display("%0t: hit_x exp %0b got %0b", $time, want.hx, m_data[24]);
                    errors++;
                end
                if (m_data[25] !== want.hy) begin
                    $display("%0t: hit_y exp %0b got %0b", $time, want.hy, m_data[25]);
                    errors++;
                end
            end
        end
        if (hold_req && hold_cnt == 0) hold_cnt = 3000;
        if (hold_cnt > 0) begin
            hold_cnt--;
            m_ready <= 1'b0;
        end else begin
            m_ready <= quiet ? 1'b1 : ($urandom_range(99) >= 14);
        end
    end

    task automatic send_beat(input tmsc_pkg::t_op op, input int idx, input int flags,
                             input int x, input int y, input int w, input int h,
                             input int mx, input int my);
        if (!quiet && $urandom_range(99) < 14) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
        end
        s_valid <= 1'b1;
        s_user  <= op;
        s_data  <= {12'(my), 12'(mx), 10'(h), 10'(w), 16'(y), 16'(x), 8'(flags), 12'(idx)};
        @(posedge i_clk);
        while (!s_ready) @(posedge i_clk);
        if (op == tmsc_pkg::OP_WRITE) tile_flags_map[idx[11:0]] = 8'(flags);
        else motion_q.push_back(sweep_rect(x, y, w, h, mx, my));
    endtask

    task automatic put_tile(input int idx, input int flags);
        send_beat(tmsc_pkg::OP_WRITE, idx, flags, 0, 0, 0, 0, 0, 0);
    endtask

    task automatic move(input int x, input int y, input int w, input int h,
                        input int mx, input int my);
        send_beat(tmsc_pkg::OP_MOVE, $urandom_range(4095), $urandom_range(255),
                  x, y, w, h, mx, my);
    endtask

    task automatic drain();
        s_valid <= 1'b0;
        while (motion_q.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    task automatic set_reg(input tmsc_pkg::t_cfg_reg r, input int v);
        drain();
        cfg_we   <= 1'b1;
        cfg_idx  <= r;
        cfg_data <= 16'(v);
        @(posedge i_clk);
        cfg_we <= 1'b0;
        case (r)
            tmsc_pkg::CFG_SOLID_MASK:  mask_q = v & 8'hFF;
            tmsc_pkg::CFG_BOUND_MIN_X: bmin_x = int'($signed(16'(v)));
            tmsc_pkg::CFG_BOUND_MIN_Y: bmin_y = int'($signed(16'(v)));
            tmsc_pkg::CFG_BOUND_MAX_X: bmax_x = int'($signed(16'(v)));
            tmsc_pkg::CFG_BOUND_MAX_Y: bmax_y = int'($signed(16'(v)));
            tmsc_pkg::CFG_TILE_WIDTH:  tile_w = v & 7'h7F;
            tmsc_pkg::CFG_TILE_HEIGHT: tile_h = v & 7'h7F;
            default: ;
        endcase
    endtask

    task automatic set_geometry(input int mask, input int tw, input int th,
                                input int x0, input int y0, input int x1, input int y1);
        set_reg(tmsc_pkg::CFG_SOLID_MASK, mask);
        set_reg(tmsc_pkg::CFG_TILE_WIDTH, tw);
        set_reg(tmsc_pkg::CFG_TILE_HEIGHT, th);
        set_reg(tmsc_pkg::CFG_BOUND_MIN_X, x0);
        set_reg(tmsc_pkg::CFG_BOUND_MIN_Y, y0);
        set_reg(tmsc_pkg::CFG_BOUND_MAX_X, x1);
        set_reg(tmsc_pkg::CFG_BOUND_MAX_Y, y1);
    endtask

    // fill the corner of the map that the moves may touch
    task automatic fill_map();
        for (int r = 0; r < REGION; r++)
            for (int c = 0; c < REGION; c++)
                put_tile(r * COLS + c, ($urandom_range(99) < 15) ? $urandom_range(1, 255) : 0);
    endtask

    function automatic int rand_span(input int lim);
        int v;
        v = $urandom_range(0, lim);
        return $urandom_range(1) ? v : -v;
    endfunction

    task automatic rand_move();
        int lx, ly;
        if ($urandom_range(99) < 4 && tile_w >= 48 && tile_h >= 48) begin
            move(int'($signed(16'($urandom))), int'($signed(16'($urandom))),
                 $urandom_range(1023), $urandom_range(1023),
                 int'($signed(12'($urandom))), int'($signed(12'($urandom))));
        end else begin
            lx = (tile_w * 6 > 2047) ? 2047 : tile_w * 6;
            ly = (tile_h * 6 > 2047) ? 2047 : tile_h * 6;
            move($urandom_range(0, 19 * tile_w) - 3 * tile_w,
                 $urandom_range(0, 19 * tile_h) - 3 * tile_h,
                 $urandom_range(0, 3 * tile_w), $urandom_range(0, 3 * tile_h),
                 rand_span(lx), rand_span(ly));
        end
    endtask

    task automatic test_edges();
        // defaults: mask 0, open field
        move(-32768, -32768, 0, 0, -5, -5);
        move(32767, 32767, 0, 0, 1, 1);
        move(-2300, 100, 4, 4, 2047, -2048);
        set_geometry(8'hFF, 8, 8, -32768, -32768, 32767, 32767);
        put_tile(10 * COLS + 10, 8'h80);
        move(60, 84, 0, 6, 40, 0);
        move(84, 60, 6, 0, 0, 40);
        move(60, 84, 6, 6, 40, 0);
        move(84, 60, 6, 6, 0, 40);
        move(82, 82, 4, 4, 3, -3);
        move(-200, 40, 300, 60, 2, -2);
        move(-32768, 32767, 1023, 1023, -1, 1);
        move(5000, -5000, 3, 3, -4, 4);
        set_geometry(8'h01, 64, 64, 0, 0, REGION * 64, REGION * 64);
        move(500, 1000, 5, 5, 2047, -2048);
        move(10, 10, 5, 5, -2048, 2047);
        move(1010, 1010, 6, 6, 8, 8);
    endtask

    task automatic test_fine_tiles();
        set_geometry(8'h0F, 1, 1, -100, -100, REGION, REGION);
        for (int i = 0; i < 30; i++) rand_move();
    endtask

    task automatic test_backpressure();
        quiet = 1'b1;
        set_geometry(8'h21, 8, 8, -32767, -32767, REGION * 8, REGION * 8);
        hold_req <= 1'b1;
        @(posedge i_clk);
        hold_req <= 1'b0;
        for (int i = 0; i < 12; i++) rand_move();
        drain();
        for (int i = 0; i < 60; i++) begin
            if ($urandom_range(9) == 0) put_tile($urandom_range(4095), $urandom_range(255));
            else rand_move();
        end
        quiet = 1'b0;
        drain();
    endtask

    task automatic test_random();
        int lo, hi, tw, th, bx, by;
        for (int ph = 0; ph < 8; ph++) begin
            if ($urandom_range(3) == 0) begin
                lo = int'($signed(16'($urandom)));
                hi = int'($signed(16'($urandom)));
            end else begin
                lo = -$urandom_range(32768, 16);
                hi = $urandom_range(32767, 300);
            end
            tw = $urandom_range(1, 64);
            th = $urandom_range(1, 64);
            bx = hi;
            by = hi - $urandom_range(1) * 3;
            if (bx > REGION * tw) bx = REGION * tw;
            if (by > REGION * th) by = REGION * th;
            set_geometry($urandom_range(255), tw, th, lo, lo + $urandom_range(1) * 7, bx, by);
            for (int i = 0; i < 50; i++) begin
                if ($urandom_range(9) == 0) put_tile($urandom_range(4095), $urandom_range(255));
                else rand_move();
            end
        end
        set_geometry(8'hFF, 64, 64, -32768, -32768, REGION * 64, REGION * 64);
        for (int i = 0; i < 40; i++) rand_move();
        set_geometry(8'h00, 2, 3, -32768, -32768, REGION * 2, REGION * 3);
        for (int i = 0; i < 40; i++) rand_move();
    endtask

    initial begin
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        fill_map();
        test_edges();
        test_fine_tiles();
        test_backpressure();
        test_random();
        drain();
        repeat (300) @(posedge i_clk);
        if (errors == 0 && motion_q.size() == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end
endmodule
`default_nettype wire

@@ filelist.f @@
sv/tmsc_pkg.sv
sv/tmsc_ram.sv
sv/tmsc_fdiv.sv
sv/tile_map_swept_collision.sv
tb/tb_tile_map_swept_collision.sv
